// ----- rtl/wscd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wscd_pkg
// Shared types, constants and the step compare for the window step change
// detector.
// ----------------------------------------------------------------------------
package wscd_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH = 5;
    localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_CNT_W   = $clog2(WINDOW_DEPTH + 1);

    // Field widths.
    localparam int SAMPLE_W = 8;
    localparam int MODE_W   = 2;
    localparam int DET_W    = 2;
    localparam int TDATA_W  = 8;

    // Reset value of the step threshold register.
    localparam logic [SAMPLE_W-1:0] STEP_THRESHOLD_RESET = SAMPLE_W'(45);

    // Watch mode codes. Any code other than idle and rise watches for a drop.
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DROP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RISE = 2'd2;

    // Detection codes.
    localparam logic [DET_W-1:0] DET_NONE = 2'd0;
    localparam logic [DET_W-1:0] DET_DROP = 2'd1;
    localparam logic [DET_W-1:0] DET_RISE = 2'd2;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // True when going from the earlier to the later sample is a step larger
    // than the threshold, in the watched direction.
    function automatic logic is_step(input sample_t earlier, input sample_t later,
                                     input logic rise, input sample_t thr);
        logic signed [SAMPLE_W+1:0] diff;
        if (rise)
        begin
            diff = $signed({2'b00, later}) - $signed({2'b00, earlier});
        end
        else
        begin
            diff = $signed({2'b00, earlier}) - $signed({2'b00, later});
        end
        return diff > $signed({2'b00, thr});
    endfunction

endpackage
`default_nettype wire

// ----- rtl/window_step_change_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// window_step_change_detector
// Detects a sudden rise or drop of the sample value over a
// window of the most recent samples.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. An accepted beat is captured in an input
// register; from there the window compare (all sample pairs of the full
// five-entry window, or only the latest stored sample while it fills; none
// in idle mode) runs and the detection code lands in the output register.
// A new beat is accepted every cycle while the output side keeps taking
// results. The window and fill count are updated only when the compared beat
// moves on into the output register, which keeps successive beats in order.
// The threshold register may be written only while no beat is in flight.
module window_step_change_detector
    import wscd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Threshold register write.
    input  wire logic               cfg_wr_en,
    input  wire logic [SAMPLE_W-1:0] cfg_wr_data,     // step_threshold
    // Sample stream in.
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,         // [7:0] sample
    input  wire logic [MODE_W-1:0]  s_tuser,         // [1:0] watch_mode
    // Detection stream out.
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic [TDATA_W-1:0] m_tdata          // [1:0] detection, rest zero
);

    logic [SAMPLE_W-1:0]   thr_reg;
    logic                  in_valid_reg;
    logic [MODE_W-1:0]     in_mode_reg;
    sample_t               in_sample_reg;
    logic                  out_valid_reg;
    logic [DET_W-1:0]      out_det_reg;
    logic [DET_W-1:0]      out_det_next;
    logic [FILL_CNT_W-1:0] fill_count_reg;
    logic [FILL_CNT_W-1:0] fill_count_next;
    sample_t               win_reg  [WINDOW_DEPTH];
    sample_t               win_next [WINDOW_DEPTH];
    logic                  out_free;
    logic                  advance;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-DET_W){1'b0}}, out_det_reg};

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= STEP_THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Window compare and state update for the beat in the input register.
    always_comb
    begin
        logic                 rise;
        logic                 hit;
        logic [DET_W-1:0]     code;
        logic [WIN_IDX_W-1:0] wr_idx;
        logic [WIN_IDX_W-1:0] prev_idx;
        sample_t              shifted [WINDOW_DEPTH];

        rise     = (in_mode_reg == MODE_RISE);
        code     = rise ? DET_RISE : DET_DROP;
        hit      = 1'b0;
        wr_idx   = fill_count_reg[WIN_IDX_W-1:0];
        prev_idx = wr_idx - WIN_IDX_W'(1);

        for (int i = 0; i < WINDOW_DEPTH - 1; i++)
        begin
            shifted[i] = win_reg[i + 1];
        end
        shifted[WINDOW_DEPTH-1] = in_sample_reg;

        win_next        = win_reg;
        fill_count_next = fill_count_reg;
        out_det_next    = DET_NONE;

        if (in_mode_reg != MODE_IDLE)
        begin
            if (fill_count_reg < FILL_CNT_W'(WINDOW_DEPTH))
            begin
                // Filling: compare only with the latest stored sample.
                if (fill_count_reg != '0 &&
                    is_step(win_reg[prev_idx], in_sample_reg, rise, thr_reg))
                begin
                    fill_count_next = '0;
                    out_det_next    = code;
                end
                else
                begin
                    win_next[wr_idx] = in_sample_reg;
                    fill_count_next  = fill_count_reg + FILL_CNT_W'(1);
                end
            end
            else
            begin
                // Full: shift the sample in, then check every ordered pair.
                win_next = shifted;
                for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                begin
                    for (int j = i + 1; j < WINDOW_DEPTH; j++)
                    begin
                        if (is_step(shifted[i], shifted[j], rise, thr_reg))
                        begin
                            hit = 1'b1;
                        end
                    end
                end
                if (hit)
                begin
                    fill_count_next = '0;
                    out_det_next    = code;
                end
            end
        end
    end

    // Pipeline control and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fill_count_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                fill_count_reg <= fill_count_next;
            end
        end
    end

    // Payload registers and sample window.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg   <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (advance)
        begin
            out_det_reg <= out_det_next;
            win_reg     <= win_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/wscd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wscd_checker
// Port-level checks for the window step change detector, bound to the top.
// ----------------------------------------------------------------------------
module wscd_checker
    import wscd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata
);

    // A stalled output beat holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // The input side only stalls when a full output register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // Only the defined detection codes appear, with zero padding above.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TDATA_W-1:DET_W] == '0 &&
                     (m_tdata[DET_W-1:0] == DET_NONE ||
                      m_tdata[DET_W-1:0] == DET_DROP ||
                      m_tdata[DET_W-1:0] == DET_RISE))
        else $error("invalid detection code");

    // An accepted beat passes both registers to the output when not stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!m_tvalid || m_tready) ##1 m_tready
        |=> m_tvalid)
        else $error("result beat missing");

endmodule

bind window_step_change_detector wscd_checker u_wscd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
